FILE: design/bat_pkg.sv
`timescale 1ns / 1ps

package bat_pkg;

  localparam int ADDR_W = 32;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic    load_req;
    logic    scan;
    logic    set_code;
    status_t code;
    logic    ins_write;
    logic    dec;
    logic    move_rd;
    logic    move_wr;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic scan_done;
    logic hit;
    logic full;
    logic need_move;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: design/bat_ctrl.sv
`timescale 1ns / 1ps

module bat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bat_pkg::dp_stat_t stat,
  output bat_pkg::dp_cmd_t  cmd
);
  import bat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.code = ST_ADDED;
    req_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_code = 1'b1;
        state_next = S_RESULT;
        if (!stat.is_remove) begin
          if (stat.hit) begin
            cmd.code = ST_PRESENT;
          end else if (stat.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.code = ST_ADDED;
            cmd.ins_write = 1'b1;
          end
        end else begin
          if (!stat.hit) begin
            cmd.code = ST_MISSING;
          end else begin
            cmd.code = ST_REMOVED;
            cmd.dec = 1'b1;
            if (stat.need_move) begin
              state_next = S_MOVE_RD;
            end
          end
        end
      end
      S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/bat_dp.sv
`timescale 1ns / 1ps

module bat_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bat_pkg::req_t     req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bat_pkg::rsp_t     rsp,
  input  bat_pkg::dp_cmd_t  cmd,
  output bat_pkg::dp_stat_t stat
);
  import bat_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_data;
  logic [IW-1:0]     rd_idx;
  logic              we;
  logic [IW-1:0]     wr_idx;
  logic [ADDR_W-1:0] wr_data;

  logic              op;
  logic [ADDR_W-1:0] address;
  logic [CW-1:0]     count;
  logic [CW-1:0]     scan_idx;
  logic [IW-1:0]     cmp_idx;
  logic              cmp_valid;
  logic              hit;
  logic [IW-1:0]     hit_idx;
  status_t           code;

  logic              issue;
  logic [CW:0]       hit_ext;
  logic [CW+ENTRY_COUNT_W-1:0] count_ext;

  assign issue = cmd.scan && (scan_idx < count);
  assign rd_idx = cmd.scan ? scan_idx[IW-1:0] : count[IW-1:0];
  assign we = cmd.ins_write || cmd.move_wr;
  assign wr_idx = cmd.move_wr ? hit_idx : count[IW-1:0];
  assign wr_data = cmd.move_wr ? rd_data : address;
  assign hit_ext = (CW+1)'(hit_idx);
  assign count_ext = (CW+ENTRY_COUNT_W)'(count);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op <= req.op;
      address <= req.address;
    end
    if (cmd.set_code) begin
      code <= cmd.code;
    end
    cmp_idx <= scan_idx[IW-1:0];
    if (cmd.scan && cmp_valid && !hit && (rd_data == address)) begin
      hit_idx <= cmp_idx;
    end
    if (cmd.load_out) begin
      rsp.status <= code;
      rsp.entry_count <= count_ext[ENTRY_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      scan_idx <= '0;
      cmp_valid <= 1'b0;
      hit <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        scan_idx <= '0;
        cmp_valid <= 1'b0;
        hit <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (cmp_valid && (rd_data == address)) begin
          hit <= 1'b1;
        end
      end
      if (cmd.ins_write) begin
        count <= count + 1'b1;
      end else if (cmd.dec) begin
        count <= count - 1'b1;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_remove = (op == OP_REMOVE);
    stat.scan_done = !issue && !cmp_valid;
    stat.hit = hit;
    stat.full = (count == CW'(TABLE_DEPTH));
    stat.need_move = (hit_ext + 1'b1) < {1'b0, count};
    stat.out_busy = rsp_valid && rsp_stall;
  end

endmodule

FILE: design/breakpoint_address_table.sv
`timescale 1ns / 1ps

// Breakpoint address table: each request beat inserts or removes one 32-bit
// address and yields one response beat with a status and the new entry count.
// Requests are handled one at a time. The live entries are compared one per
// cycle through the single read port of the entry memory, and a remove that
// hits any entry but the last moves the last entry into the freed slot. A new
// request is taken while the previous response still waits in the output
// register.
module breakpoint_address_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bat_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bat_pkg::rsp_t rsp
);
  import bat_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (TABLE_DEPTH > 31 || int'(rsp.entry_count) <= TABLE_DEPTH))
    else $error("response entry count exceeds table depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !stat.out_busy)
    else $error("response register loaded while stalled");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> (!stat.full && !stat.hit))
    else $error("insert written into a full table or as a duplicate");

  a_move_order: assert property (@(posedge clk) disable iff (rst)
    cmd.move_wr |-> $past(cmd.move_rd))
    else $error("move write without a preceding read");
`endif

endmodule

FILE: test/breakpoint_address_table_tb.sv
`timescale 1ns / 1ps

module breakpoint_address_table_tb;
  import bat_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1525;
  localparam int POOL_SIZE = 24;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] address;
    bit                typed;
    status_t           status;
    logic [4:0]        count;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  breakpoint_address_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  logic [ADDR_W-1:0] shadow_addr [DEPTH];
  int                shadow_count;
  rsp_t              pending_rsp [$];
  dir_row_t          dir_rows [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  int                errors;
  int                sent;
  int                status_seen [5];
  bit                send_quiet;
  bit                recv_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("breakpoint_address_table: mismatch");
    $finish;
  end

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    bit   hit;
    int   slot;
    hit = 1'b0;
    slot = 0;
    for (int k = 0; k < shadow_count; k++) begin
      if (!hit && shadow_addr[k] == r.address) begin
        hit = 1'b1;
        slot = k;
      end
    end
    if (r.op == OP_INSERT) begin
      if (hit) begin
        o.status = ST_PRESENT;
      end else if (shadow_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        shadow_addr[shadow_count] = r.address;
        shadow_count++;
        o.status = ST_ADDED;
      end
    end else begin
      if (!hit) begin
        o.status = ST_MISSING;
      end else begin
        shadow_count--;
        if (slot < shadow_count) begin
          shadow_addr[slot] = shadow_addr[shadow_count];
        end
        o.status = ST_REMOVED;
      end
    end
    o.entry_count = 5'(shadow_count);
    return o;
  endfunction

  task automatic add_row(input logic op, input logic [ADDR_W-1:0] address, input bit typed,
                         input status_t status, input logic [4:0] count);
    dir_row_t row;
    row.op = op;
    row.address = address;
    row.typed = typed;
    row.status = status;
    row.count = count;
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    int   gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = apply_request(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    sent++;
  endtask

  initial begin
    int beats;
    int wait_cycles;
    rsp_t exp_rsp;
    beats = 0;
    recv_quiet = 1'b0;
    forever begin
      wait_cycles = recv_quiet ? 0 : $urandom_range(0, 14);
      if (wait_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (rsp_valid !== 1'b1) @(posedge clk);
      beats++;
      if (beats % 100 == 0) begin
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      if (rsp.status <= ST_MISSING) begin
        status_seen[rsp.status]++;
      end
      if (pending_rsp.size() == 0) begin
        $error("unexpected response beat: status %0d entry_count %0d",
               rsp.status, rsp.entry_count);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
          errors++;
        end
        if (rsp.entry_count !== exp_rsp.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 exp_rsp.entry_count, rsp.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    req_t r;
    rsp_t typed_rsp;
    int   ins_pct;
    int   sel;
    int   drain;
    errors = 0;
    sent = 0;
    shadow_count = 0;
    send_quiet = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      shadow_addr[k] = '0;
    end
    for (int k = 0; k < 5; k++) begin
      status_seen[k] = 0;
    end
    for (int k = 0; k < POOL_SIZE; k++) begin
      addr_pool[k] = $urandom;
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;

    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(OP_REMOVE, 32'h1234_5678, 1, ST_MISSING, 5'd0);
    add_row(OP_INSERT, 32'h0000_0000, 1, ST_ADDED, 5'd1);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 1, ST_ADDED, 5'd2);
    add_row(OP_INSERT, 32'h0000_0000, 1, ST_PRESENT, 5'd2);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 1, ST_REMOVED, 5'd1);
    add_row(OP_REMOVE, 32'h0000_0000, 1, ST_REMOVED, 5'd0);
    for (int k = 0; k < DEPTH; k++) begin
      add_row(OP_INSERT, 32'h0000_0001 << (2 * k), 1, ST_ADDED, 5'(k + 1));
    end
    add_row(OP_INSERT, 32'hFFFF_FFFF, 1, ST_FULL, 5'd16);
    add_row(OP_INSERT, 32'h0000_0001, 1, ST_PRESENT, 5'd16);
    add_row(OP_REMOVE, 32'h0000_0001, 1, ST_REMOVED, 5'd15);
    add_row(OP_REMOVE, 32'h0000_0001, 1, ST_MISSING, 5'd15);
    add_row(OP_INSERT, 32'h4000_0000, 0, ST_ADDED, 5'd0);

    foreach (dir_rows[i]) begin
      r.op = dir_rows[i].op;
      r.address = dir_rows[i].address;
      typed_rsp.status = dir_rows[i].status;
      typed_rsp.entry_count = dir_rows[i].count;
      send_request(r, dir_rows[i].typed, typed_rsp);
    end

    ins_pct = 50;
    typed_rsp = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 85;
          1: ins_pct = 50;
          default: ins_pct = 15;
        endcase
      end
      if (n % 100 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
      end
      r.op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      sel = $urandom_range(0, 9);
      if (sel < 4 && shadow_count > 0) begin
        r.address = shadow_addr[$urandom_range(0, shadow_count - 1)];
      end else if (sel < 7) begin
        r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        r.address = $urandom;
      end
      send_request(r, 0, typed_rsp);
    end
    req_valid <= 1'b0;

    drain = 0;
    while (pending_rsp.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d response beats never arrived", pending_rsp.size());
      errors++;
    end

    $display("Sent %0d insert and remove requests, directed corner cases first.", sent);
    $display("Statuses seen: added %0d, present %0d, full %0d, removed %0d, missing %0d.",
             status_seen[ST_ADDED], status_seen[ST_PRESENT], status_seen[ST_FULL],
             status_seen[ST_REMOVED], status_seen[ST_MISSING]);
    if (errors == 0) begin
      $display("breakpoint_address_table: match");
    end else begin
      $display("breakpoint_address_table: mismatch");
    end
    $finish;
  end

endmodule
